[hw/rtl/kvd_pkg.sv]
// Shared types and constants for the key vector debouncer.
// No dependencies; used by the interfaces and every module of the block.
package kvd_pkg;

   localparam int KEY_COUNT = 16;
   localparam int VEC_W     = 16;
   localparam int KEY_SEL_W = $clog2(VEC_W);
   localparam int IDX_W     = 8;
   localparam int TIME_W    = 32;
   localparam int DEB_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [VEC_W-1:0] KEY_MASK =
      VEC_W'((VEC_W+1)'(1) << KEY_COUNT) - VEC_W'(1);
   localparam logic [IDX_W-1:0] KEY_LIMIT = IDX_W'(KEY_COUNT);

   // item kinds
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS = CSR_IDX_W'(1);

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(20);

   typedef struct packed {
      logic              func;
      logic [VEC_W-1:0]  raw_bits;
      logic [TIME_W-1:0] now_ms;
      logic [IDX_W-1:0]  key_index;
   } req_type;

   typedef struct packed {
      logic [VEC_W-1:0] stable_keys;
      logic [VEC_W-1:0] raw_keys;
      logic [VEC_W-1:0] pending_edges;
      logic             key_pressed;
      logic             key_just_pressed;
   } rsp_type;

   typedef struct packed {
      logic             active_low;
      logic [DEB_W-1:0] debounce_ms;
   } cfg_type;

endpackage

[hw/rtl/kvd_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on kvd_pkg for field widths.
interface kvd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [kvd_pkg::VEC_W-1:0]       raw_bits;
   logic [kvd_pkg::TIME_W-1:0]      now_ms;
   logic [kvd_pkg::IDX_W-1:0]       key_index;

   modport source (output valid, func, raw_bits, now_ms, key_index, input ready);
   modport sink   (input valid, func, raw_bits, now_ms, key_index, output ready);
endinterface

interface kvd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [kvd_pkg::VEC_W-1:0]       stable_keys;
   logic [kvd_pkg::VEC_W-1:0]       raw_keys;
   logic [kvd_pkg::VEC_W-1:0]       pending_edges;
   logic                            key_pressed;
   logic                            key_just_pressed;

   modport source (output valid, stable_keys, raw_keys, pending_edges, key_pressed,
                   key_just_pressed, input ready);
   modport sink   (input valid, stable_keys, raw_keys, pending_edges, key_pressed,
                   key_just_pressed, output ready);
endinterface

[hw/rtl/kvd_csr.sv]
// Configuration registers: active-low select and debounce time.
// Depends on kvd_pkg.
module kvd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kvd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kvd_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output kvd_pkg::cfg_type                  cfg
);

   kvd_pkg::cfg_type cfg_ff;
   kvd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            kvd_pkg::CSR_ACTIVE_LOW:  cfg_in.active_low  = csr_wdata[0];
            kvd_pkg::CSR_DEBOUNCE_MS: cfg_in.debounce_ms = csr_wdata[kvd_pkg::DEB_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low  <= 1'b0;
         cfg_ff.debounce_ms <= kvd_pkg::DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/kvd_core.sv]
// Debounce state and per-beat update: candidate/stable tracking, edge flags,
// key queries. Depends on kvd_pkg.
module kvd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  kvd_pkg::req_type     req,
   input  kvd_pkg::cfg_type     cfg,
   output kvd_pkg::rsp_type     rsp
);

   logic [kvd_pkg::VEC_W-1:0]     raw_ff, raw_in;
   logic [kvd_pkg::VEC_W-1:0]     cand_ff, cand_in;
   logic [kvd_pkg::VEC_W-1:0]     stable_ff, stable_in;
   logic [kvd_pkg::VEC_W-1:0]     edge_ff, edge_in;
   logic [kvd_pkg::TIME_W-1:0]    change_ff, change_in;

   logic [kvd_pkg::VEC_W-1:0]     cond_bits;
   logic [kvd_pkg::TIME_W-1:0]    elapsed;
   logic                          hold_done;
   logic                          in_range;
   logic [kvd_pkg::KEY_SEL_W-1:0] key_sel;
   logic                          pressed;
   logic                          just;

   assign cond_bits = (cfg.active_low ? ~req.raw_bits : req.raw_bits) & kvd_pkg::KEY_MASK;
   assign elapsed   = req.now_ms - change_ff;
   assign hold_done = elapsed >= {{(kvd_pkg::TIME_W-kvd_pkg::DEB_W){1'b0}}, cfg.debounce_ms};
   assign in_range  = req.key_index < kvd_pkg::KEY_LIMIT;
   assign key_sel   = req.key_index[kvd_pkg::KEY_SEL_W-1:0];

   always_comb begin
      raw_in    = raw_ff;
      cand_in   = cand_ff;
      stable_in = stable_ff;
      edge_in   = edge_ff;
      change_in = change_ff;
      pressed   = 1'b0;
      just      = 1'b0;
      unique case (req.func)
         kvd_pkg::FUNC_SAMPLE: begin
            raw_in = cond_bits;
            if (cond_bits != cand_ff) begin
               // restart the hold window
               cand_in   = cond_bits;
               change_in = req.now_ms;
            end else if (cond_bits != stable_ff && hold_done) begin
               stable_in = cond_bits;
               edge_in   = edge_ff | (cond_bits & ~stable_ff);
            end
         end
         kvd_pkg::FUNC_QUERY: begin
            if (in_range) begin
               pressed          = stable_ff[key_sel];
               just             = edge_ff[key_sel];
               edge_in[key_sel] = 1'b0;
            end
         end
         default: begin
            raw_in = raw_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= '0;
         cand_ff   <= '0;
         stable_ff <= '0;
         edge_ff   <= '0;
         change_ff <= '0;
      end else if (fire) begin
         raw_ff    <= raw_in;
         cand_ff   <= cand_in;
         stable_ff <= stable_in;
         edge_ff   <= edge_in;
         change_ff <= change_in;
      end
   end

   assign rsp.stable_keys      = stable_in;
   assign rsp.raw_keys         = raw_in;
   assign rsp.pending_edges    = edge_in;
   assign rsp.key_pressed      = pressed;
   assign rsp.key_just_pressed = just;

endmodule

[hw/rtl/key_vector_debouncer_top.sv]
// Key vector debouncer top level: input register, state update, result register.
// Beats go from the input register through the core into the result register.
// Throughput: one beat per cycle unless rsp_ch stalls; state update compares.
// Reset: synchronous, active high; clears all debounce state, both stage valids,
// and sets active_low to 0 and debounce_ms to 20. Depends on kvd_pkg, kvd_if.
module key_vector_debouncer_top (
   input  logic                          clock,
   input  logic                          reset,
   kvd_req_if.sink                       req_ch,
   kvd_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [kvd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kvd_pkg::CSR_DAT_W-1:0] csr_wdata
);

   kvd_pkg::cfg_type cfg;
   kvd_pkg::req_type req_beat;
   kvd_pkg::req_type in_data_ff;
   kvd_pkg::rsp_type rsp_next;
   kvd_pkg::rsp_type out_data_ff;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic             req_fire;

   assign req_beat.func      = req_ch.func;
   assign req_beat.raw_bits  = req_ch.raw_bits;
   assign req_beat.now_ms    = req_ch.now_ms;
   assign req_beat.key_index = req_ch.key_index;

   // advance the held beat when the result register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   kvd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kvd_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_beat;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.stable_keys      = out_data_ff.stable_keys;
   assign rsp_ch.raw_keys         = out_data_ff.raw_keys;
   assign rsp_ch.pending_edges    = out_data_ff.pending_edges;
   assign rsp_ch.key_pressed      = out_data_ff.key_pressed;
   assign rsp_ch.key_just_pressed = out_data_ff.key_just_pressed;

endmodule

[tb/key_vector_debouncer_top_test.sv]
// Self-checking test of key_vector_debouncer_top: directed and random key scans and queries.
// A debounce predictor checks every response beat; depends on kvd_pkg and kvd_if.
module key_vector_debouncer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [kvd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [kvd_pkg::CSR_DAT_W-1:0] csr_wdata;

   kvd_req_if req_ch ();
   kvd_rsp_if rsp_ch ();

   key_vector_debouncer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic                       cfg_active_low = 1'b0;
   logic [kvd_pkg::DEB_W-1:0]  cfg_debounce   = kvd_pkg::DEBOUNCE_RESET;
   logic [kvd_pkg::VEC_W-1:0]  raw_vec    = '0;
   logic [kvd_pkg::VEC_W-1:0]  cand_vec   = '0;
   logic [kvd_pkg::VEC_W-1:0]  stable_vec = '0;
   logic [kvd_pkg::VEC_W-1:0]  prev_vec   = '0;
   logic [kvd_pkg::VEC_W-1:0]  edge_vec   = '0;
   logic [kvd_pkg::TIME_W-1:0] change_ms  = '0;

   kvd_pkg::rsp_type status_q[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               idle_pct    = 0;
   int               stall_pct   = 0;

   // random scan generator state
   logic [kvd_pkg::TIME_W-1:0] scan_ms;
   logic [kvd_pkg::VEC_W-1:0]  target_keys;
   int                         repeats_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic kvd_pkg::rsp_type debounce_step(input kvd_pkg::req_type item);
      kvd_pkg::rsp_type           res;
      logic [kvd_pkg::VEC_W-1:0]  cond;
      logic [kvd_pkg::TIME_W-1:0] elapsed;
      logic [kvd_pkg::KEY_SEL_W-1:0] sel;
      res = '0;
      sel = item.key_index[kvd_pkg::KEY_SEL_W-1:0];
      if (item.func == kvd_pkg::FUNC_SAMPLE) begin
         cond = (cfg_active_low ? ~item.raw_bits : item.raw_bits) & kvd_pkg::KEY_MASK;
         raw_vec = cond;
         if (cond != cand_vec) begin
            cand_vec  = cond;
            change_ms = item.now_ms;
         end else begin
            elapsed = item.now_ms - change_ms;
            if (cond != stable_vec && elapsed >= kvd_pkg::TIME_W'(cfg_debounce)) begin
               prev_vec   = stable_vec;
               stable_vec = cond;
               edge_vec   = edge_vec | (stable_vec & ~prev_vec);
            end
         end
      end else if (item.key_index < kvd_pkg::KEY_LIMIT) begin
         res.key_pressed      = stable_vec[sel];
         res.key_just_pressed = edge_vec[sel];
         edge_vec[sel]        = 1'b0;
      end
      res.stable_keys   = stable_vec;
      res.raw_keys      = raw_vec;
      res.pending_edges = edge_vec;
      return res;
   endfunction

   // check the response first: it never belongs to a request taken at the same edge
   always @(posedge clock) begin
      kvd_pkg::rsp_type want;
      kvd_pkg::req_type item;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (status_q.size() == 0) begin
            $error("response beat with no expectation waiting");
            error_count++;
         end else begin
            want = status_q.pop_front();
            if (rsp_ch.stable_keys !== want.stable_keys) begin
               $error("stable_keys expected %h actual %h", want.stable_keys, rsp_ch.stable_keys);
               error_count++;
            end
            if (rsp_ch.raw_keys !== want.raw_keys) begin
               $error("raw_keys expected %h actual %h", want.raw_keys, rsp_ch.raw_keys);
               error_count++;
            end
            if (rsp_ch.pending_edges !== want.pending_edges) begin
               $error("pending_edges expected %h actual %h",
                      want.pending_edges, rsp_ch.pending_edges);
               error_count++;
            end
            if (rsp_ch.key_pressed !== want.key_pressed) begin
               $error("key_pressed expected %b actual %b", want.key_pressed, rsp_ch.key_pressed);
               error_count++;
            end
            if (rsp_ch.key_just_pressed !== want.key_just_pressed) begin
               $error("key_just_pressed expected %b actual %b",
                      want.key_just_pressed, rsp_ch.key_just_pressed);
               error_count++;
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         item.func      = req_ch.func;
         item.raw_bits  = req_ch.raw_bits;
         item.now_ms    = req_ch.now_ms;
         item.key_index = req_ch.key_index;
         status_q.push_back(debounce_step(item));
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("key_vector_debouncer_top verification failed");
         $finish;
      end
   end

   task automatic send_beat(input kvd_pkg::req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= item.func;
      req_ch.raw_bits  <= item.raw_bits;
      req_ch.now_ms    <= item.now_ms;
      req_ch.key_index <= item.key_index;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_sample(input logic [kvd_pkg::VEC_W-1:0] bits,
                              input logic [kvd_pkg::TIME_W-1:0] stamp);
      kvd_pkg::req_type item;
      item.func      = kvd_pkg::FUNC_SAMPLE;
      item.raw_bits  = bits;
      item.now_ms    = stamp;
      item.key_index = kvd_pkg::IDX_W'($urandom);
      send_beat(item);
   endtask

   task automatic send_query(input logic [kvd_pkg::IDX_W-1:0] key);
      kvd_pkg::req_type item;
      item.func      = kvd_pkg::FUNC_QUERY;
      item.raw_bits  = kvd_pkg::VEC_W'($urandom);
      item.now_ms    = $urandom;
      item.key_index = key;
      send_beat(item);
   endtask

   // drop valid, wait out every pending response and the pipeline
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic al, input logic [kvd_pkg::DEB_W-1:0] deb);
      settle();
      csr_we    <= 1'b1;
      csr_index <= kvd_pkg::CSR_ACTIVE_LOW;
      csr_wdata <= kvd_pkg::CSR_DAT_W'(al);
      @(posedge clock);
      csr_index <= kvd_pkg::CSR_DEBOUNCE_MS;
      csr_wdata <= kvd_pkg::CSR_DAT_W'(deb);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_active_low = al;
      cfg_debounce   = deb;
      @(posedge clock);
   endtask

   task automatic test_directed_defaults();
      idle_pct  = 0;
      stall_pct = 0;
      send_query(kvd_pkg::IDX_W'(0));
      send_sample(16'hFFFF, 32'd100);
      send_sample(16'hFFFF, 32'd119);
      send_sample(16'hFFFF, 32'd120);
      send_query(kvd_pkg::IDX_W'(0));
      send_query(kvd_pkg::IDX_W'(15));
      send_query(kvd_pkg::IDX_W'(16));
      send_query(kvd_pkg::IDX_W'(255));
      send_query(kvd_pkg::IDX_W'(0));
      // elapsed time across the timestamp wrap
      send_sample(16'h00F0, 32'hFFFF_FFF0);
      send_sample(16'h00F0, 32'h0000_0003);
      send_sample(16'h00F0, 32'h0000_0004);
      send_sample(16'h0000, 32'd5);
      send_sample(16'h0000, 32'hFFFF_FFFF);
      settle();
   endtask

   task automatic test_directed_config();
      configure(1'b1, kvd_pkg::DEB_W'(0));
      send_sample(16'h0000, 32'd0);
      send_sample(16'h0000, 32'd0);
      send_query(kvd_pkg::IDX_W'(3));
      send_sample(16'hFFFF, 32'd7);
      send_sample(16'hFFFF, 32'd7);
      configure(1'b0, kvd_pkg::DEB_W'(16'hFFFF));
      send_sample(16'h8001, 32'd1000);
      send_sample(16'h8001, 32'd1000 + 32'd65534);
      send_sample(16'h8001, 32'd1000 + 32'd65535);
      send_query(kvd_pkg::IDX_W'(15));
      send_query(kvd_pkg::IDX_W'(0));
      settle();
   endtask

   function automatic logic [kvd_pkg::TIME_W-1:0] next_step_ms();
      logic [kvd_pkg::TIME_W-1:0] deb;
      int                         mode;
      deb  = kvd_pkg::TIME_W'(cfg_debounce);
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1:    return '0;
         2, 3, 4: return $urandom_range(0, deb);
         5, 6:    return deb;
         7:       return (deb == 0) ? '0 : deb - 1;
         8:       return $urandom_range(deb, deb * 3 + 5);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random(input int count, input int idle, input int stall,
                              input logic al, input logic [kvd_pkg::DEB_W-1:0] deb);
      int                        pick;
      int                        flips;
      logic [kvd_pkg::VEC_W-1:0] keys;
      configure(al, deb);
      idle_pct  = idle;
      stall_pct = stall;
      scan_ms   = $urandom;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            if ($urandom_range(0, 4) == 0)
               send_query(kvd_pkg::IDX_W'($urandom_range(16, 255)));
            else
               send_query(kvd_pkg::IDX_W'($urandom_range(0, 15)));
         end else if (pick < 32) begin
            send_sample(kvd_pkg::VEC_W'($urandom), $urandom);
         end else begin
            if (repeats_left == 0) begin
               flips = $urandom_range(0, 9);
               if (flips < 5) begin
                  repeat ($urandom_range(1, 3))
                     target_keys[$urandom_range(0, kvd_pkg::VEC_W - 1)] ^= 1'b1;
               end else if (flips < 8) begin
                  target_keys = kvd_pkg::VEC_W'($urandom);
               end else begin
                  target_keys = flips[0] ? '1 : '0;
               end
               repeats_left = $urandom_range(1, 5);
            end
            scan_ms = scan_ms + next_step_ms();
            // bounce: a stray vector in the middle of a settling run
            if ($urandom_range(0, 9) == 0) begin
               keys = kvd_pkg::VEC_W'($urandom);
            end else begin
               keys = target_keys;
               repeats_left--;
            end
            send_sample(cfg_active_low ? ~keys : keys, scan_ms);
         end
      end
      settle();
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= kvd_pkg::FUNC_SAMPLE;
      req_ch.raw_bits  <= '0;
      req_ch.now_ms    <= '0;
      req_ch.key_index <= '0;
      csr_we           <= 1'b0;
      csr_index        <= kvd_pkg::CSR_ACTIVE_LOW;
      csr_wdata        <= '0;
      target_keys       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_defaults();
      test_directed_config();
      test_random(280, 0, 0, 1'b0, kvd_pkg::DEBOUNCE_RESET);
      test_random(280, 72, 0, 1'b1, kvd_pkg::DEB_W'(0));
      test_random(280, 0, 72, 1'b0, kvd_pkg::DEB_W'(16'hFFFF));
      test_random(280, 15, 15, 1'b1, kvd_pkg::DEB_W'($urandom));
      test_random(280, 0, 0, 1'b0, kvd_pkg::DEB_W'($urandom_range(1, 100)));
      if (error_count == 0 && status_q.size() == 0)
         $display("key_vector_debouncer_top verification clean");
      else
         $display("key_vector_debouncer_top verification failed");
      $finish;
   end

endmodule
